/* hw/rtl/hred_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hred_pkg;

  // Header key that carries the body length, matched case-insensitively.
  localparam int unsigned KeyLen = 15;
  localparam logic [7:0] KEY_TEXT [16] = '{
    8'h63, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
    8'h6c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a, 8'h00
  };

  // Characters that steer the parser.
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
  localparam logic [7:0] CHAR_LOW_C = 8'h63;

  // Phases of the length value parser.
  localparam logic [1:0] PHASE_KEY    = 2'd0;
  localparam logic [1:0] PHASE_BLANKS = 2'd1;
  localparam logic [1:0] PHASE_DIGITS = 2'd2;
  localparam logic [1:0] PHASE_DONE   = 2'd3;

  // Completion reasons.
  localparam logic [1:0] REASON_NONE     = 2'd0;
  localparam logic [1:0] REASON_COMPLETE = 2'd1;
  localparam logic [1:0] REASON_LIMIT    = 2'd2;

  // Largest magnitude of the length value.
  localparam int unsigned MagBits = 31;
  localparam logic [MagBits-1:0] MAG_MAX = '1;

  // Header parsing state.
  typedef struct packed {
    logic [3:0]         key_pos;
    logic [1:0]         phase;
    logic               negative;
    logic [MagBits-1:0] magnitude;
    logic [1:0]         blank_pos;
    logic               hdr_done;
  } hred_parse_t;

endpackage

`default_nettype wire

/* hw/rtl/hred_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Next header parsing state for one request byte.
module hred_parser (
  input  wire logic [7:0]          data_byte_i,
  input  wire hred_pkg::hred_parse_t state_i,
  output hred_pkg::hred_parse_t    state_o
);
  import hred_pkg::*;

  logic [7:0]         lower;
  logic               is_digit;
  logic [3:0]         digit_val;
  logic [MagBits+4:0] mag_wide;
  logic [MagBits-1:0] mag_next;
  logic [7:0]         want;

  assign is_digit  = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
  assign lower     = ((data_byte_i >= CHAR_UP_A) && (data_byte_i <= CHAR_UP_Z)) ?
                     data_byte_i + 8'd32 : data_byte_i;
  // A digit's value is the low nibble of its character code.
  assign digit_val = data_byte_i[3:0];

  // Times ten plus the digit, as two shifts and two adds, then saturate.
  assign mag_wide = ({5'd0, state_i.magnitude} << 3) + ({5'd0, state_i.magnitude} << 1)
                  + {{(MagBits+5-4){1'b0}}, digit_val};
  assign mag_next = (mag_wide > {5'd0, MAG_MAX}) ? MAG_MAX : mag_wide[MagBits-1:0];

  assign want = state_i.blank_pos[0] ? CHAR_LF : CHAR_CR;

  always_comb begin
    state_o = state_i;
    if (!state_i.hdr_done) begin
      // Key search and value parsing.
      unique case (state_i.phase)
        PHASE_KEY: begin
          if ((state_i.key_pos < 4'(KeyLen)) && (lower == KEY_TEXT[state_i.key_pos])) begin
            state_o.key_pos = state_i.key_pos + 4'd1;
            if (state_i.key_pos == 4'(KeyLen - 1)) begin
              state_o.phase = PHASE_BLANKS;
            end
          end else begin
            state_o.key_pos = (lower == CHAR_LOW_C) ? 4'd1 : 4'd0;
          end
        end
        PHASE_BLANKS: begin
          if ((data_byte_i == CHAR_SPACE) || (data_byte_i == CHAR_TAB)) begin
            state_o.phase = PHASE_BLANKS;
          end else if ((data_byte_i == CHAR_PLUS) || (data_byte_i == CHAR_MINUS)) begin
            state_o.negative = (data_byte_i == CHAR_MINUS);
            state_o.phase    = PHASE_DIGITS;
          end else if (is_digit) begin
            state_o.magnitude = mag_next;
            state_o.phase     = PHASE_DIGITS;
          end else begin
            state_o.phase = PHASE_DONE;
          end
        end
        PHASE_DIGITS: begin
          if (is_digit) begin
            state_o.magnitude = mag_next;
          end else begin
            state_o.phase = PHASE_DONE;
          end
        end
        default: begin
          state_o.phase = PHASE_DONE;
        end
      endcase

      // Blank line tracking.
      if (data_byte_i == want) begin
        if (state_i.blank_pos == 2'd3) begin
          state_o.blank_pos = 2'd0;
          state_o.hdr_done  = 1'b1;
        end else begin
          state_o.blank_pos = state_i.blank_pos + 2'd1;
        end
      end else begin
        state_o.blank_pos = (data_byte_i == CHAR_CR) ? 2'd1 : 2'd0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/http_request_end_detector_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// config    in         cfg_we_i                 cfg_data_i (max_request_bytes)
// byte in   in         in_valid_i / in_ready_o  data_byte_i, new_request_i
// result    out        out_valid_o / out_ready_i done_res_o, done_reason_o,
//                                               declared_length_o, bytes_seen_o,
//                                               headers_ended_o
//
// One byte is accepted per cycle while the result is not stalled. The accepting edge
// updates the parse state and counters; the length and limit comparison on that state
// is then loaded into the result register, from which the result is offered. Reset
// clears all parse state and loads the byte limit with 16383.
// A stalled result holds both stages; input is taken again once a stage frees up.
module http_request_end_detector_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               new_request_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    done_res_o,
  output logic [1:0]              done_reason_o,
  output logic signed [31:0]      declared_length_o,
  output logic [15:0]             bytes_seen_o,
  output logic                    headers_ended_o
);
  import hred_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [15:0]           max_bytes_q;
  hred_parse_t           parse_q, parse_base, parse_next;
  logic [COUNT_BITS-1:0] total_q, total_base, total_d;
  logic [COUNT_BITS-1:0] body_q, body_base, body_d;
  logic                  stage_valid_q;
  logic                  stage_move;
  logic                  in_fire;
  logic                  out_free;
  logic [31:0]           body_ext, total_ext, mag_ext;
  logic [1:0]            reason;

  // Limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= 16'd16383;
    end else if (cfg_we_i) begin
      max_bytes_q <= cfg_data_i;
    end
  end

  // Handshake between the state stage and the result register.
  assign out_free   = !out_valid_o || out_ready_i;
  assign stage_move = stage_valid_q && out_free;
  assign in_ready_o = !stage_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // A new request starts from a cleared state.
  assign parse_base = new_request_i ? '0 : parse_q;
  assign total_base = new_request_i ? '0 : total_q;
  assign body_base  = new_request_i ? '0 : body_q;

  hred_parser u_parser (
    .data_byte_i (data_byte_i),
    .state_i     (parse_base),
    .state_o     (parse_next)
  );

  // Saturating byte counters.
  assign total_d = (total_base == COUNT_MAX) ? total_base : total_base + COUNT_BITS'(1);
  assign body_d  = !parse_base.hdr_done ? body_base :
                   (body_base == COUNT_MAX) ? body_base : body_base + COUNT_BITS'(1);

  // Parse state stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q       <= '0;
      total_q       <= '0;
      body_q        <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        parse_q <= parse_next;
        total_q <= total_d;
        body_q  <= body_d;
      end
      if (in_fire) begin
        stage_valid_q <= 1'b1;
      end else if (stage_move) begin
        stage_valid_q <= 1'b0;
      end
    end
  end

  // Completion check on the updated state.
  assign body_ext  = 32'(body_q);
  assign total_ext = 32'(total_q);
  assign mag_ext   = {1'b0, parse_q.magnitude};

  always_comb begin
    if (parse_q.hdr_done && (parse_q.negative || (mag_ext == 32'd0) ||
                             (body_ext >= mag_ext))) begin
      reason = REASON_COMPLETE;
    end else if (total_ext >= {16'd0, max_bytes_q}) begin
      reason = REASON_LIMIT;
    end else begin
      reason = REASON_NONE;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (stage_move) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (stage_move) begin
      done_res_o        <= (reason != REASON_NONE);
      done_reason_o     <= reason;
      declared_length_o <= parse_q.negative ? -$signed(mag_ext) : $signed(mag_ext);
      bytes_seen_o      <= total_ext[15:0];
      headers_ended_o   <= parse_q.hdr_done;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_http_request_end_detector_unit.sv */
`timescale 1ns / 1ps

module tb_http_request_end_detector_unit;
  import hred_pkg::*;

  localparam logic [8*15-1:0] KEY_BITS = "content-length:";
  localparam logic [15:0] COUNT_TOP = 16'hffff;
  localparam logic [31:0] LEN_TOP = 32'h7fff_ffff;
  localparam logic [15:0] LIMIT_AT_RESET = 16'd16383;

  // One expected completion verdict per accepted byte.
  typedef struct packed {
    logic               done;
    logic [1:0]         reason;
    logic signed [31:0] length;
    logic [15:0]        seen;
    logic               hdr_end;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic new_request_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic done_res_o;
  logic [1:0] done_reason_o;
  logic signed [31:0] declared_length_o;
  logic [15:0] bytes_seen_o;
  logic headers_ended_o;

  // Parser state mirrored by the predictor.
  logic [3:0]  key_pos = '0;
  logic [1:0]  val_phase = PHASE_KEY;
  logic        val_neg = 1'b0;
  logic [31:0] len_mag = '0;
  logic [1:0]  crlf_pos = '0;
  logic        hdr_seen = 1'b0;
  logic [15:0] total_cnt = '0;
  logic [15:0] body_cnt = '0;
  logic [15:0] byte_limit = LIMIT_AT_RESET;

  verdict_t verdict_q[$];
  logic [7:0] msg_bytes[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left = 0;

  http_request_end_detector_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .new_request_i    (new_request_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .done_res_o       (done_res_o),
    .done_reason_o    (done_reason_o),
    .declared_length_o(declared_length_o),
    .bytes_seen_o     (bytes_seen_o),
    .headers_ended_o  (headers_ended_o)
  );

  // Free-running 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Give up on a hung run.
  initial begin
    #3ms;
    $display("[http_request_end_detector_unit] ERROR");
    $finish;
  end

  // Result ready: random stalls, or a long hold-off while stall_left runs down.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic clear_parser();
    key_pos = '0;
    val_phase = PHASE_KEY;
    val_neg = 1'b0;
    len_mag = '0;
    crlf_pos = '0;
    hdr_seen = 1'b0;
    total_cnt = '0;
    body_cnt = '0;
  endtask

  // Multiply by ten and add one digit, saturating at the largest magnitude.
  task automatic accumulate_digit(input logic [7:0] c);
    longint next_mag;
    next_mag = longint'(len_mag) * 10 + longint'(c - CHAR_ZERO);
    len_mag = (next_mag > longint'(LEN_TOP)) ? LEN_TOP : next_mag[31:0];
  endtask

  // Advance the mirrored parser by one byte and queue the verdict it implies.
  task automatic predict_verdict(input logic [7:0] c, input logic fresh);
    logic [7:0] lc;
    logic is_digit;
    longint len;
    verdict_t v;
    if (fresh) clear_parser();
    if (total_cnt != COUNT_TOP) total_cnt++;
    if (hdr_seen) begin
      if (body_cnt != COUNT_TOP) body_cnt++;
    end else begin
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      lc = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + 8'd32 : c;
      // Length header key search and value parse.
      case (val_phase)
        PHASE_KEY: begin
          if (key_pos < KeyLen && lc == KEY_BITS[8*(14-int'(key_pos)) +: 8]) begin
            key_pos = key_pos + 4'd1;
            if (key_pos == KeyLen) val_phase = PHASE_BLANKS;
          end else begin
            key_pos = (lc == CHAR_LOW_C) ? 4'd1 : 4'd0;
          end
        end
        PHASE_BLANKS: begin
          if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            val_neg = (c == CHAR_MINUS);
            val_phase = PHASE_DIGITS;
          end else if (is_digit) begin
            accumulate_digit(c);
            val_phase = PHASE_DIGITS;
          end else if (c != CHAR_SPACE && c != CHAR_TAB) begin
            val_phase = PHASE_DONE;
          end
        end
        PHASE_DIGITS: begin
          if (is_digit) accumulate_digit(c);
          else val_phase = PHASE_DONE;
        end
        default: ;
      endcase
      // Blank line detection.
      if (c == (crlf_pos[0] ? CHAR_LF : CHAR_CR)) begin
        if (crlf_pos == 2'd3) begin
          crlf_pos = 2'd0;
          hdr_seen = 1'b1;
        end else begin
          crlf_pos = crlf_pos + 2'd1;
        end
      end else begin
        crlf_pos = (c == CHAR_CR) ? 2'd1 : 2'd0;
      end
    end
    len = val_neg ? -longint'(len_mag) : longint'(len_mag);
    v.reason = REASON_NONE;
    if (hdr_seen && (len <= 0 || longint'(body_cnt) >= len)) v.reason = REASON_COMPLETE;
    else if (total_cnt >= byte_limit) v.reason = REASON_LIMIT;
    v.done = (v.reason != REASON_NONE);
    v.length = len[31:0];
    v.seen = total_cnt;
    v.hdr_end = hdr_seen;
    verdict_q.push_back(v);
  endtask

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // Compare every result taken with the oldest pending verdict.
  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: result with no request pending", $time);
      end else begin
        want = verdict_q.pop_front();
        if (done_res_o !== want.done) note_mismatch("done_res", want.done, done_res_o);
        if (done_reason_o !== want.reason)
          note_mismatch("done_reason", want.reason, done_reason_o);
        if (declared_length_o !== want.length)
          note_mismatch("declared_length", $signed(want.length), $signed(declared_length_o));
        if (bytes_seen_o !== want.seen) note_mismatch("bytes_seen", want.seen, bytes_seen_o);
        if (headers_ended_o !== want.hdr_end)
          note_mismatch("headers_ended", want.hdr_end, headers_ended_o);
      end
    end
  end

  // Offer one byte request, with random gaps, and hold it until taken.
  task automatic send_byte(input logic [7:0] value, input logic fresh);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= value;
    new_request_i <= fresh;
    do @(posedge clk_i); while (!in_ready_o);
    predict_verdict(value, fresh);
  endtask

  // Stop offering and wait until every pending verdict has been checked.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [15:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    byte_limit = value;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic push_crlf();
    msg_bytes.push_back(CHAR_CR);
    msg_bytes.push_back(CHAR_LF);
  endtask

  // The length key with each letter in random case.
  task automatic push_key();
    logic [7:0] ch;
    for (int i = 0; i < KeyLen; i++) begin
      ch = KEY_BITS[8*(14-i) +: 8];
      if (ch >= "a" && ch <= "z" && $urandom_range(1)) ch = ch - 8'd32;
      msg_bytes.push_back(ch);
    end
  endtask

  task automatic send_message(input logic fresh);
    for (int i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], (i == 0) ? fresh : 1'b0);
  endtask

  // Mostly well-formed HTTP messages with random content and value forms.
  task automatic build_random_message();
    int value_kind;
    int body_len;
    msg_bytes.delete();
    push_text($urandom_range(1) ? "GET /" : "POST /");
    repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(33, 126)));
    push_crlf();
    // A near miss of the key first restarts the key search.
    if ($urandom_range(3) == 0) begin
      push_text("content-lenc");
      push_crlf();
    end
    body_len = $urandom_range(0, 12);
    if ($urandom_range(9) != 0) begin
      push_key();
      repeat ($urandom_range(0, 2)) msg_bytes.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      value_kind = $urandom_range(9);
      case (value_kind)
        0: begin
          msg_bytes.push_back(CHAR_MINUS);
          push_text($sformatf("%0d", $urandom_range(0, 50)));
        end
        1: begin
          msg_bytes.push_back(CHAR_PLUS);
          push_text($sformatf("%0d", body_len));
        end
        2: msg_bytes.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
        3: msg_bytes.push_back(8'($urandom_range(65, 122)));
        4: repeat ($urandom_range(10, 12)) msg_bytes.push_back(8'($urandom_range(48, 57)));
        default: push_text($sformatf("%0d", body_len + $urandom_range(0, 2)));
      endcase
      push_crlf();
      // Later keys must not change the value.
      if ($urandom_range(3) == 0) begin
        push_key();
        push_text($sformatf(" %0d", $urandom_range(0, 99)));
        push_crlf();
      end
    end
    if ($urandom_range(1)) begin
      push_text("Host: h");
      push_crlf();
    end
    push_crlf();
    repeat (body_len + $urandom_range(0, 2)) msg_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Plain message with a short body, zero and all-ones data, then extra bytes.
  task automatic test_basic_request();
    msg_bytes.delete();
    push_text("POST / HTTP/1.1");
    push_crlf();
    push_text("Content-Length: 3");
    push_crlf();
    push_crlf();
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hff);
    push_text("content-length:0");
    send_message(1'b1);
  endtask

  task automatic test_value_forms();
    // Upper case key, tab and blank before a negative value.
    msg_bytes.delete();
    push_text("CONTENT-Length:");
    msg_bytes.push_back(CHAR_TAB);
    push_text(" -12");
    push_crlf();
    push_crlf();
    push_text("x");
    send_message(1'b1);
    // A sign without digits finishes the value at zero.
    msg_bytes.delete();
    push_text("content-length:+");
    push_crlf();
    push_crlf();
    send_message(1'b1);
    // A letter in place of the value.
    msg_bytes.delete();
    push_text("Content-Length: x5");
    push_crlf();
    push_crlf();
    send_message(1'b1);
    // Oversized negative value saturates.
    msg_bytes.delete();
    push_text("content-length: -99999999999");
    push_crlf();
    push_crlf();
    push_text("ab");
    send_message(1'b1);
    // Stray c before the key, then a second key that is ignored.
    msg_bytes.delete();
    push_text("ccontent-length: 2");
    push_crlf();
    push_text("content-length: 9");
    push_crlf();
    push_crlf();
    push_text("abc");
    send_message(1'b1);
    // Continuation without clearing: the parse state carries over.
    msg_bytes.delete();
    push_text("Q");
    send_message(1'b0);
  endtask

  // Byte limit extremes, including a limit of zero and reason priority.
  task automatic test_byte_limits();
    set_limit(16'd0);
    msg_bytes.delete();
    push_text("GET /");
    push_crlf();
    push_crlf();
    send_message(1'b1);
    set_limit(16'd1);
    msg_bytes.delete();
    push_text("ab");
    send_message(1'b1);
    set_limit(16'hffff);
    test_basic_request();
    set_limit(16'd6);
    build_random_message();
    send_message(1'b1);
  endtask

  // Receiver holds off long enough to fill the block while bytes keep coming.
  task automatic test_backpressure();
    build_random_message();
    stall_left = 300;
    send_message(1'b1);
    build_random_message();
    send_message(1'b1);
    drain_results();
    build_random_message();
    send_message(1'b1);
  endtask

  // Long body against the largest declared length, cut off by the byte limit.
  task automatic test_long_body();
    set_limit(16'd100);
    msg_bytes.delete();
    push_text("content-length: 2147483647");
    push_crlf();
    push_crlf();
    repeat (120) msg_bytes.push_back(8'($urandom_range(255)));
    send_message(1'b1);
    set_limit(LIMIT_AT_RESET);
  endtask

  task automatic test_random(input int unsigned n_items, input logic [15:0] limit);
    int unsigned sent;
    set_limit(limit);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(4) == 0) begin
        // Raw noise with occasional clears.
        repeat ($urandom_range(1, 24)) begin
          send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
          sent++;
        end
      end else begin
        build_random_message();
        send_message($urandom_range(9) != 0);
        sent += msg_bytes.size();
      end
    end
  endtask

  initial begin : run_tests
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 88;
    test_basic_request();
    test_value_forms();
    test_byte_limits();
    test_random(350, 16'($urandom_range(12, 90)));

    send_idle_pct = 88;
    recv_idle_pct = 28;
    test_backpressure();
    test_random(350, 16'($urandom_range(1, 65535)));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_long_body();
    test_random(350, 16'($urandom_range(8, 40)));

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[http_request_end_detector_unit] OK");
    end else begin
      $display("[http_request_end_detector_unit] ERROR");
    end
    $finish;
  end

endmodule
